// ----- src/ptm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg: shared constants for the page table map insert core
// Table geometry, entry masks and flag bits of the four-level page tables.
// ----------------------------------------------------------------------------
package ptm_pkg;

  // Number of 4 KiB tables held in the table store (root included).
  localparam int unsigned NUM_TABLES = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned TIDX_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TABLES + 1);
  localparam int unsigned STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
  localparam int unsigned ST_ADDR_W = TIDX_W + IDX_W;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned PG_W = ADDR_W - 12;

  localparam logic [ENTRY_W-1:0] PAGE_MASK_4K = 64'h0000_FFFF_FFFF_F000;
  localparam logic [ENTRY_W-1:0] PAGE_MASK_2M = 64'h0000_FFFF_FFE0_0000;
  localparam logic [ENTRY_W-1:0] FLAG_PRESENT = 64'h1;
  localparam logic [ENTRY_W-1:0] FLAG_WRITE = 64'h2;
  localparam logic [ENTRY_W-1:0] FLAG_SIZE_2M = 64'h80;
  localparam logic [ADDR_W-1:0] ROOT_RESET = 48'h3000;

  // Result status codes.
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

endpackage

// ----- src/ptm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/page_table_map_insert_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_insert_core: four-level page table map insert
// Walks the page tables held in an internal store, allocates missing tables
// with a bump allocator and writes the leaf entry, one result per entry.
// ----------------------------------------------------------------------------
// Walk: reads one level per cycle, then writes one entry per cycle while the
//   result register can take it; each written entry goes out as a result.
// Requests: one is taken only once the last has finished; a 4 KiB map
//   that allocates tables takes the longest, since each level waits on the last.
// Reset: the store is cleared one entry per cycle (32768 entries for 64 tables);
//   s_axis_tready stays low meanwhile, cfg writes are still taken.
// ----------------------------------------------------------------------------
module page_table_map_insert_core (
  input  logic          clk,
  input  logic          rst,
  // Configuration: table_base, physical address of the root table.
  input  logic          cfg_wen,
  input  logic [47:0]   cfg_wdata,
  // Request stream.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // map_vaddr [47:0], phys_page [95:48]
  input  logic          s_axis_tuser,   // large_page
  // Result stream.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // entry_addr [47:0], entry_value [111:48]
  output logic          m_axis_tuser,   // status
  output logic          m_axis_tlast    // last
);

  localparam int unsigned TIDX_W = ptm_pkg::TIDX_W;
  localparam int unsigned CNT_W = ptm_pkg::CNT_W;
  localparam int unsigned IDX_W = ptm_pkg::IDX_W;
  localparam int unsigned PG_W = ptm_pkg::PG_W;
  localparam int unsigned SA_W = ptm_pkg::ST_ADDR_W;

  // The walk: CLEAR zeroes the store after reset, WALK checks one level per cycle
  // as read data returns, WRITE stores one entry per cycle while the result slot
  // is free (new tables first, leaf last), ERROR returns the single error result.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_WRITE,
    ST_ERROR
  } state_t;

  state_t state;

  logic [47:0]       table_base;
  logic [47:0]       va;
  logic [47:0]       pa;
  logic              big_page;
  logic [1:0]        lvl;
  logic [TIDX_W-1:0] k;
  logic [CNT_W-1:0]  nfree;
  logic [SA_W-1:0]   clr_addr;

  // Table store port signals.
  logic              mem_we;
  logic [SA_W-1:0]   mem_waddr;
  logic [63:0]       mem_wdata;
  logic              mem_re;
  logic [SA_W-1:0]   mem_raddr;
  logic [63:0]       mem_rdata;

  logic              accept;
  logic              slot_free;
  logic              emit;
  logic [1:0]        inner;
  logic [1:0]        lvl_inc;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  nxt_idx;
  logic [PG_W-1:0]   cur_tbl;
  logic [PG_W-1:0]   alloc_tbl;
  logic [PG_W-1:0]   ptr_off;
  logic              ptr_ok;
  logic [1:0]        need;
  logic              fits;
  logic [63:0]       new_entry;
  logic [63:0]       leaf_entry;
  logic [47:0]       entry_addr;

  function automatic logic [IDX_W-1:0] level_index(logic [47:0] addr, logic [1:0] l);
    logic [IDX_W-1:0] r;
    case (l)
      2'd0:    r = addr[47:39];
      2'd1:    r = addr[38:30];
      2'd2:    r = addr[29:21];
      default: r = addr[20:12];
    endcase
    return r;
  endfunction

  ptm_ram #(
    .WIDTH (ptm_pkg::ENTRY_W),
    .DEPTH (ptm_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  // The result register may take a new result when empty or being drained.
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  // A result is loaded in this cycle.
  assign emit = ((state == ST_WRITE) || (state == ST_ERROR)) && slot_free;

  always_comb begin
    inner = big_page ? 2'd2 : 2'd3;
    lvl_inc = lvl + 2'd1;
    cur_idx = level_index(va, lvl);
    nxt_idx = level_index(va, lvl_inc);
    cur_tbl = table_base[47:12] + PG_W'(k);
    alloc_tbl = table_base[47:12] + PG_W'(nfree);
    entry_addr = {cur_tbl, cur_idx, 3'b000};

    // A nonzero upper-level entry must point at a table already handed out.
    ptr_off = mem_rdata[47:12] - table_base[47:12];
    ptr_ok = (ptr_off < PG_W'(nfree));

    // Tables still missing below a zero entry at the current level.
    need = inner - lvl;
    fits = ((CNT_W + 2)'(nfree) + (CNT_W + 2)'(need)) <= (CNT_W + 2)'(ptm_pkg::NUM_TABLES);

    new_entry = {16'b0, alloc_tbl, 12'b0} | ptm_pkg::FLAG_PRESENT | ptm_pkg::FLAG_WRITE;
    if (big_page) begin
      leaf_entry = ({16'b0, pa} & ptm_pkg::PAGE_MASK_2M) | ptm_pkg::FLAG_PRESENT
                   | ptm_pkg::FLAG_WRITE | ptm_pkg::FLAG_SIZE_2M;
    end else begin
      leaf_entry = ({16'b0, pa} & ptm_pkg::PAGE_MASK_4K) | ptm_pkg::FLAG_PRESENT
                   | ptm_pkg::FLAG_WRITE;
    end

    // Read port: root entry on accept, next level while the walk goes deeper.
    mem_re = 1'b0;
    mem_raddr = {{TIDX_W{1'b0}}, s_axis_tdata[47:39]};
    if (state == ST_IDLE) begin
      mem_re = accept;
    end else if (state == ST_WALK) begin
      mem_raddr = {ptr_off[TIDX_W-1:0], nxt_idx};
      mem_re = (mem_rdata != 64'b0) && ptr_ok && (lvl_inc != inner);
    end

    // Write port: clearing pass, or one walk entry when the result can go out.
    mem_we = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 64'b0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_WRITE) begin
      mem_we = slot_free;
      mem_waddr = {k, cur_idx};
      mem_wdata = (lvl != inner) ? new_entry : leaf_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      table_base <= ptm_pkg::ROOT_RESET;
      nfree <= CNT_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        table_base <= cfg_wdata;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + SA_W'(1);
          if (clr_addr == SA_W'(ptm_pkg::STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            va <= s_axis_tdata[47:0];
            pa <= s_axis_tdata[95:48];
            big_page <= s_axis_tuser;
            lvl <= 2'd0;
            k <= '0;
            state <= ST_WALK;
          end
        end

        ST_WALK: begin
          if (mem_rdata == 64'b0) begin
            // Everything from this level down is new; check the allocator.
            state <= fits ? ST_WRITE : ST_ERROR;
          end else if (!ptr_ok) begin
            state <= ST_ERROR;
          end else begin
            k <= ptr_off[TIDX_W-1:0];
            lvl <= lvl_inc;
            if (lvl_inc == inner) begin
              state <= ST_WRITE;
            end
          end
        end

        ST_WRITE: begin
          if (slot_free) begin
            m_axis_tdata <= {mem_wdata, entry_addr};
            m_axis_tuser <= ptm_pkg::STATUS_OK;
            if (lvl != inner) begin
              m_axis_tlast <= 1'b0;
              k <= nfree[TIDX_W-1:0];
              nfree <= nfree + CNT_W'(1);
              lvl <= lvl_inc;
            end else begin
              m_axis_tlast <= 1'b1;
              state <= ST_IDLE;
            end
          end
        end

        ST_ERROR: begin
          if (slot_free) begin
            m_axis_tdata <= '0;
            m_axis_tuser <= ptm_pkg::STATUS_ERROR;
            m_axis_tlast <= 1'b1;
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The allocator never runs past the store and never hands out the root.
  a_nfree_range: assert property (@(posedge clk) disable iff (rst)
    (nfree != '0) && (nfree <= CNT_W'(ptm_pkg::NUM_TABLES)))
    else $error("free table counter out of range");

  // Entries are only written into tables that have been handed out.
  a_write_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (CNT_W'(k) < nfree))
    else $error("write into a table not yet allocated");

  // The table store is never written while a new request may be taken.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !mem_we)
    else $error("table store written while idle");

  // An error result is always the only and last result of its request.
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error result without last mark");

endmodule

// ----- tb/page_table_map_insert_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_map_insert_core_tb: regression bench for the page table map core
// Drives map requests with random gaps and compares every written table
// entry against a shadow copy of the tables, the allocator and table_base.
// ----------------------------------------------------------------------------
module page_table_map_insert_core_tb;

  localparam int unsigned ADDR_W = ptm_pkg::ADDR_W;
  localparam int unsigned ENTRY_W = ptm_pkg::ENTRY_W;
  localparam int unsigned IDX_W = ptm_pkg::IDX_W;
  localparam int unsigned ST_ADDR_W = ptm_pkg::ST_ADDR_W;
  localparam int unsigned STORE_DEPTH = ptm_pkg::STORE_DEPTH;
  localparam int unsigned NUM_TABLES = ptm_pkg::NUM_TABLES;
  localparam int unsigned ENTRIES_PER_TABLE = ptm_pkg::ENTRIES_PER_TABLE;

  // Idle cycles without any handshake before the run is declared hung. The
  // store clear after reset runs with tready low and no handshake at all.
  localparam int unsigned WATCHDOG_LIMIT = 150000;
  // Quiet cycles after the last result before table_base may change.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_GAP = 6;
  localparam int unsigned RANDOM_MAPS = 350;

  // One table entry write as it leaves the result stream.
  typedef struct packed {
    logic [ADDR_W-1:0]  entry_addr;
    logic [ENTRY_W-1:0] entry_value;
    logic               status;
    logic               last;
  } pte_write_t;

  // Every input of the core has a known value from time zero.
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wen = 1'b0;
  logic [47:0]   cfg_wdata = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;   // map_vaddr [47:0], phys_page [95:48]
  logic          s_axis_tuser = 1'b0; // large_page
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;        // entry_addr [47:0], entry_value [111:48]
  logic          m_axis_tuser;        // status
  logic          m_axis_tlast;        // last

  // Shadow of the core: table contents, allocator and root address.
  logic [ENTRY_W-1:0] shadow_tables [STORE_DEPTH];
  logic [ADDR_W-1:0]  shadow_base;
  int unsigned        shadow_next_table;

  // Entry writes predicted but not yet seen on the result stream.
  pte_write_t pending_writes[$];
  int unsigned error_count = 0;

  // When set, neither side inserts idle cycles.
  bit no_idle = 1'b0;
  // Tracks what the request valid was last driven to, so that it is never
  // lowered and raised again within one time step.
  bit req_held = 1'b0;
  int unsigned sink_wait = 0;

  page_table_map_insert_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow model of the table walk.
  // --------------------------------------------------------------------------

  function automatic void clear_shadow();
    for (int unsigned i = 0; i < STORE_DEPTH; i++) begin
      shadow_tables[ST_ADDR_W'(i)] = '0;
    end
    shadow_base = ptm_pkg::ROOT_RESET;
    shadow_next_table = 1;
  endfunction

  // Physical address of table k; the low 12 bits of the base do not count
  // and the sum wraps at 48 bits.
  function automatic logic [ADDR_W-1:0] table_phys(input int unsigned k);
    return {shadow_base[ADDR_W-1:12], 12'h000} + (ADDR_W'(k) << 12);
  endfunction

  // A nonzero entry is taken as a pointer. It is only usable when it lands on
  // a table that the allocator has already handed out under the current base.
  function automatic bit follow_pointer(input logic [ENTRY_W-1:0] ent,
                                        output int unsigned k);
    logic [ADDR_W-1:0] off;
    off = {ent[ADDR_W-1:12], 12'h000} - {shadow_base[ADDR_W-1:12], 12'h000};
    k = 0;
    if (off[ADDR_W-1:12] >= shadow_next_table || off[ADDR_W-1:12] >= NUM_TABLES) begin
      return 1'b0;
    end
    k = int'(off[ADDR_W-1:12]);
    return 1'b1;
  endfunction

  function automatic void expect_write(input logic [ADDR_W-1:0] addr,
                                       input logic [ENTRY_W-1:0] value,
                                       input logic status, input logic last);
    pte_write_t w;
    w.entry_addr = addr;
    w.entry_value = value;
    w.status = status;
    w.last = last;
    pending_writes.push_back(w);
  endfunction

  // Works out every entry that one accepted map request writes.
  function automatic void predict_map(input logic [ADDR_W-1:0] va,
                                      input logic [ADDR_W-1:0] pa,
                                      input logic big_page);
    logic [IDX_W-1:0]     ix [4];
    logic [ENTRY_W-1:0]   ent;
    logic [ENTRY_W-1:0]   leaf;
    int                   depth;
    int                   l;
    int unsigned          k;
    int unsigned          nk;
    int unsigned          need;
    logic [ST_ADDR_W-1:0] slot;
    bit                   fresh;
    ix[0] = va[47:39];
    ix[1] = va[38:30];
    ix[2] = va[29:21];
    ix[3] = va[20:12];
    depth = big_page ? 2 : 3;

    // First pass only counts the tables to allocate and checks each pointer,
    // so that a refused request leaves the tables untouched.
    k = 0;
    need = 0;
    fresh = 1'b0;
    for (l = 0; l < depth; l++) begin
      if (fresh) begin
        need++;
      end else begin
        slot = ST_ADDR_W'(k * ENTRIES_PER_TABLE + ix[l]);
        ent = shadow_tables[slot];
        if (ent == '0) begin
          need++;
          fresh = 1'b1;
        end else if (!follow_pointer(ent, nk)) begin
          expect_write('0, '0, ptm_pkg::STATUS_ERROR, 1'b1);
          return;
        end else begin
          k = nk;
        end
      end
    end
    if (shadow_next_table + need > NUM_TABLES) begin
      expect_write('0, '0, ptm_pkg::STATUS_ERROR, 1'b1);
      return;
    end

    // Second pass allocates missing tables from the root downward.
    k = 0;
    for (l = 0; l < depth; l++) begin
      slot = ST_ADDR_W'(k * ENTRIES_PER_TABLE + ix[l]);
      ent = shadow_tables[slot];
      if (ent == '0) begin
        nk = shadow_next_table;
        shadow_next_table++;
        ent = ENTRY_W'(table_phys(nk)) | ptm_pkg::FLAG_PRESENT | ptm_pkg::FLAG_WRITE;
        shadow_tables[slot] = ent;
        expect_write(table_phys(k) + ADDR_W'({ix[l], 3'b000}), ent,
                     ptm_pkg::STATUS_OK, 1'b0);
      end else begin
        void'(follow_pointer(ent, nk));
      end
      k = nk;
    end

    // The leaf replaces whatever the entry held, a table pointer included.
    slot = ST_ADDR_W'(k * ENTRIES_PER_TABLE + ix[depth]);
    if (big_page) begin
      leaf = (ENTRY_W'(pa) & ptm_pkg::PAGE_MASK_2M) | ptm_pkg::FLAG_PRESENT
             | ptm_pkg::FLAG_WRITE | ptm_pkg::FLAG_SIZE_2M;
    end else begin
      leaf = (ENTRY_W'(pa) & ptm_pkg::PAGE_MASK_4K) | ptm_pkg::FLAG_PRESENT
             | ptm_pkg::FLAG_WRITE;
    end
    shadow_tables[slot] = leaf;
    expect_write(table_phys(k) + ADDR_W'({ix[depth], 3'b000}), leaf,
                 ptm_pkg::STATUS_OK, 1'b1);
  endfunction

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------

  // Sends one map request after a random gap and predicts its writes once it
  // has been accepted. Valid stays high afterwards so that back-to-back
  // requests need no second assignment in the same step.
  task automatic send_map(input logic [ADDR_W-1:0] va, input logic [ADDR_W-1:0] pa,
                          input logic big_page);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      if (req_held) begin
        s_axis_tvalid <= 1'b0;
        req_held = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pa, va};
    s_axis_tuser <= big_page;
    req_held = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_map(va, pa, big_page);
  endtask

  task automatic park_requests();
    if (req_held) begin
      s_axis_tvalid <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  // Holds off new requests until every predicted write has come back, then
  // lets the core settle.
  task automatic wait_for_drain();
    park_requests();
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // table_base only changes while the core is idle.
  task automatic write_table_base(input logic [ADDR_W-1:0] base);
    wait_for_drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_base = base;
  endtask

  // Random addresses mostly reuse a few indexes per level, so that walks go
  // through existing tables and the small table pool lasts. Large pages use
  // their own third-level indexes so they rarely cover the 4 KiB tables.
  function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] fav_a,
                                                  input logic [IDX_W-1:0] fav_b);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return fav_a;
    end
    if (roll < 8) begin
      return fav_b;
    end
    return IDX_W'($urandom);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_va(input logic big_page);
    logic [IDX_W-1:0] mid_ix;
    mid_ix = big_page ? pick_index(9'd1, 9'd510) : pick_index(9'd0, 9'd511);
    return {pick_index(9'd0, 9'd511), pick_index(9'd0, 9'd511), mid_ix,
            IDX_W'($urandom), 12'($urandom)};
  endfunction

  function automatic logic [ADDR_W-1:0] random_phys();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, then a field by field compare.
  // --------------------------------------------------------------------------

  // After each accepted result the sink draws how long it stays stalled.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_wait = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      m_axis_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_axis_tready <= (sink_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pte_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected result: addr %h value %h status %b last %b", $time,
                 m_axis_tdata[47:0], m_axis_tdata[111:48], m_axis_tuser, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tdata[47:0] !== want.entry_addr) begin
          $display("%0t: entry_addr expected %h actual %h", $time,
                   want.entry_addr, m_axis_tdata[47:0]);
          error_count++;
        end
        if (m_axis_tdata[111:48] !== want.entry_value) begin
          $display("%0t: entry_value expected %h actual %h", $time,
                   want.entry_value, m_axis_tdata[111:48]);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either stream restarts the count.
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("page_table_map_insert_core regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Field extremes, both page sizes, reuse of tables, a 2 MiB leaf replacing
  // a table pointer and a 4 KiB map that runs into a 2 MiB page.
  task automatic test_directed_maps();
    send_map(48'h0000_0000_0000, 48'h0000_0000_0000, 1'b0);
    send_map(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_map(48'h0000_0000_1000, random_phys(), 1'b0);
    // Allocates a page table under third-level entry 1 ...
    send_map(48'h0000_0020_5000, random_phys(), 1'b0);
    // ... which a 2 MiB leaf then replaces ...
    send_map(48'h0000_0020_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
    // ... so a 4 KiB map below it finds a leaf instead of a table.
    send_map(48'h0000_0020_3000, random_phys(), 1'b0);
    send_map(48'hFFFF_FFDF_FFFF, 48'h0000_0000_0000, 1'b1);
    send_map(48'h0080_0000_0000, 48'h1234_5678_9ABC, 1'b1);
    send_map(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0);
    send_map(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1);
    // Let everything drain once before remapping existing pages.
    wait_for_drain();
    send_map(48'h0000_0000_0FFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_map(48'h0080_0000_0000, 48'h0000_0020_0000, 1'b1);
    send_map(48'h0080_0000_1000, random_phys(), 1'b0);
  endtask

  // Root address at both ends of its range and far from the tables in use.
  // Fresh roots show the wrapped table addresses; old pointers no longer
  // decode under a base that moved far away.
  task automatic test_table_base_settings();
    write_table_base(48'hFFFF_FFFF_FFFF);
    send_map(48'h0100_0000_0000, random_phys(), 1'b0);
    write_table_base(48'h0000_0000_0000);
    send_map(48'h0180_0000_0000, random_phys(), 1'b1);
    write_table_base(48'h8000_0000_0ABC);
    send_map(48'h0000_0000_0000, random_phys(), 1'b0);
    send_map(48'hFFFF_FFFF_F000, random_phys(), 1'b1);
    // Back to the original tables; the low 12 bits must not matter.
    write_table_base({36'h0_0000_0003, 12'($urandom)});
  endtask

  task automatic test_random_maps();
    int unsigned n;
    logic        big_page;
    for (n = 0; n < RANDOM_MAPS; n++) begin
      // Roughly one stretch in four runs with no idling on either side.
      if (n % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_MAPS / 2) begin
        write_table_base({36'h0_0000_0003, 12'($urandom)});
      end
      big_page = ($urandom_range(0, 3) == 0);
      send_map(pick_va(big_page), random_phys(), big_page);
    end
    no_idle = 1'b0;
  endtask

  // Random top-level maps until under three tables are left (20 at most), then
  // three more; one that needs more tables than are left is refused untouched.
  task automatic test_table_exhaustion();
    int unsigned n;
    n = 0;
    while (shadow_next_table + 3 <= NUM_TABLES && n < 20) begin
      send_map({IDX_W'($urandom), 27'($urandom), 12'h000}, random_phys(), 1'b0);
      n++;
    end
    repeat (3) begin
      send_map({IDX_W'($urandom), 27'($urandom), 12'h000}, random_phys(), 1'b0);
    end
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // The core clears its table store before it takes the first request;
    // send_map simply waits for tready through that.
    test_directed_maps();
    test_table_base_settings();
    test_random_maps();
    test_table_exhaustion();
    wait_for_drain();
    if (error_count == 0) begin
      $display("page_table_map_insert_core regression: pass");
    end else begin
      $display("page_table_map_insert_core regression: fail");
    end
    $finish;
  end

endmodule
